@@ sv/bgr888_to_rgb565_window_writer_defines.svh @@
// Assertion macros shared by the window writer modules.
`ifndef BGR888_TO_RGB565_WINDOW_WRITER_DEFINES_SVH
`define BGR888_TO_RGB565_WINDOW_WRITER_DEFINES_SVH

// The condition holds in the same cycle as the trigger.
`define B2R_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition holds in the cycle after the trigger.
`define B2R_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/b2r_pkg.sv @@
// Types, constants and the color packing function of the window writer.
package b2r_pkg;

  localparam int unsigned CoordW = 9;

  localparam logic [CoordW-1:0] LIMIT_X   = 9'd320;
  localparam logic [CoordW-1:0] LIMIT_Y   = 9'd240;
  localparam logic [CoordW-1:0] MAX_COORD = 9'd511;

  localparam logic [CoordW-1:0] START_X_RESET = 9'd0;
  localparam logic [CoordW-1:0] START_Y_RESET = 9'd0;
  localparam logic [CoordW-1:0] END_X_RESET   = 9'd319;
  localparam logic [CoordW-1:0] END_Y_RESET   = 9'd239;

  localparam logic [1:0] REG_START_X = 2'd0;
  localparam logic [1:0] REG_START_Y = 2'd1;
  localparam logic [1:0] REG_END_X   = 2'd2;
  localparam logic [1:0] REG_END_Y   = 2'd3;

  // Position of a word within its three-word group.
  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;

  typedef struct packed {
    logic restart;
    logic advance;
  } cursor_step_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } cursor_pos_t;

  // Pixel 0 takes B0/G0 from the held word and R0 from the low byte of the
  // current word; pixel 1 takes B1 from the held high byte and G1/R1 here.
  function automatic logic [15:0] pack_rgb565(input logic [15:0] held,
                                              input logic [15:0] word,
                                              input logic        second_pixel);
    logic [15:0] color;
    if (second_pixel) begin
      color = {word[15:11], word[7:2], held[15:11]};
    end else begin
      color = {word[7:3], held[15:10], held[7:3]};
    end
    return color;
  endfunction

endpackage

@@ sv/b2r_cursor.sv @@
// Window cursor: walks y fastest, then steps x with saturation.
`include "bgr888_to_rgb565_window_writer_defines.svh"

module b2r_cursor (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [b2r_pkg::CoordW-1:0] start_x,
  input  logic [b2r_pkg::CoordW-1:0] start_y,
  input  logic [b2r_pkg::CoordW-1:0] end_y,
  input  b2r_pkg::cursor_step_t      step,
  output b2r_pkg::cursor_pos_t       pos
);
  import b2r_pkg::*;

  logic [CoordW-1:0] cur_x;
  logic [CoordW-1:0] cur_y;
  logic [CoordW-1:0] cur_x_next;
  logic [CoordW-1:0] cur_y_next;
  logic [CoordW:0]   y_inc;

  // A restart takes effect for the word that carries it.
  assign pos.x = step.restart ? start_x : cur_x;
  assign pos.y = step.restart ? start_y : cur_y;
  assign y_inc = {1'b0, pos.y} + {{CoordW{1'b0}}, 1'b1};

  always_comb begin
    cur_x_next = pos.x;
    cur_y_next = pos.y;
    if (step.advance) begin
      if (y_inc > {1'b0, end_y}) begin
        cur_y_next = start_y;
        if (pos.x < MAX_COORD) begin
          cur_x_next = pos.x + 9'd1;
        end
      end else begin
        cur_y_next = y_inc[CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x <= START_X_RESET;
      cur_y <= START_Y_RESET;
    end else begin
      cur_x <= cur_x_next;
      cur_y <= cur_y_next;
    end
  end

  `B2R_ASSERT_NEXT(a_x_never_backs, step.advance && !step.restart, cur_x >= $past(cur_x), "cursor x moved back without a restart")
  `B2R_ASSERT_NEXT(a_restart_loads, step.restart && !step.advance, (cur_x == $past(start_x)) && (cur_y == $past(start_y)), "restart did not load the window start")
  `B2R_ASSERT_NEXT(a_y_wraps_to_start, step.advance && (y_inc > {1'b0, end_y}), cur_y == $past(start_y), "cursor y did not return to the window start y")

endmodule

@@ sv/bgr888_to_rgb565_window_writer.sv @@
// Packed BGR888 word stream to RGB565 pixels with window coordinates.
// The block takes one 16-bit word per clock while the downstream is ready:
// each three-word group yields up to two pixels, from its
// second and third words, and a pixel appears on the output in the cycle after
// the word that completes it. A word is taken whenever the single output
// register is empty or being drained in the same cycle, so throughput is
// set only by the downstream ready. Pixels whose cursor lies beyond x 320
// or y 240 are dropped while the cursor still advances. Window registers
// are written through the cfg port; a start flag in tuser reloads the cursor.
`include "bgr888_to_rgb565_window_writer_defines.svh"

module bgr888_to_rgb565_window_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] packed_word
  input  logic        s_axis_tuser,  // [0] picture_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [8:0] pixel_x, [16:9] pixel_y, [32:17] pixel_color
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import b2r_pkg::*;

  logic [CoordW-1:0] start_x;
  logic [CoordW-1:0] start_y;
  logic [CoordW-1:0] end_y;

  logic [15:0] held_word;
  logic [1:0]  word_phase;
  logic [1:0]  word_phase_next;
  logic [1:0]  cur_phase;

  logic         s_accept;
  logic         pixel_step;
  logic         in_bounds;
  logic [15:0]  color;
  cursor_step_t step;
  cursor_pos_t  pos;

  logic        out_valid;
  logic [32:0] out_data;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // A start request makes this word the first of a group.
  assign cur_phase  = s_axis_tuser ? PHASE_FIRST : word_phase;
  assign pixel_step = (cur_phase == PHASE_SECOND) || (cur_phase == PHASE_THIRD);

  assign step.restart = s_accept && s_axis_tuser;
  assign step.advance = s_accept && pixel_step;

  b2r_cursor u_cursor (
    .clk     (clk),
    .rst     (rst),
    .start_x (start_x),
    .start_y (start_y),
    .end_y   (end_y),
    .step    (step),
    .pos     (pos)
  );

  assign in_bounds = (pos.x <= LIMIT_X) && (pos.y <= LIMIT_Y);
  assign color     = pack_rgb565(held_word, s_axis_tdata, cur_phase == PHASE_THIRD);

  always_comb begin
    case (cur_phase)
      PHASE_SECOND: word_phase_next = PHASE_THIRD;
      PHASE_THIRD:  word_phase_next = PHASE_FIRST;
      default:      word_phase_next = PHASE_SECOND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= START_X_RESET;
      start_y <= START_Y_RESET;
      end_y   <= END_Y_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_X: start_x <= cfg_data;
        REG_START_Y: start_y <= cfg_data;
        // The window end x only sizes the sender's word count, so it is not stored.
        REG_END_X:   ;
        REG_END_Y:   end_y   <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_word  <= '0;
      word_phase <= PHASE_FIRST;
    end else if (s_accept) begin
      held_word  <= s_axis_tdata;
      word_phase <= word_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && !m_axis_tready) || (s_accept && pixel_step && in_bounds);
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && pixel_step && in_bounds) begin
      out_data <= {color, pos.y[7:0], pos.x};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_data};

  `B2R_ASSERT_NEXT(a_start_group, s_accept && s_axis_tuser, word_phase == PHASE_SECOND, "start word did not open a new group")
  `B2R_ASSERT_NEXT(a_first_word_silent, s_accept && (cur_phase == PHASE_FIRST) && !out_valid, !m_axis_tvalid, "first word of a group produced a pixel")
  `B2R_ASSERT_IMPLY(a_out_in_bounds, m_axis_tvalid, (m_axis_tdata[8:0] <= LIMIT_X) && ({1'b0, m_axis_tdata[16:9]} <= LIMIT_Y), "pixel outside the panel limits was sent")

endmodule
